// ===== rtl/cva_pkg.sv =====
// shared types, codes and coin profile tables for the coin validator accumulator
// no dependencies
package cva_pkg;

	localparam int NUM_SENSORS = 8;
	localparam int NUM_KINDS   = 4;
	localparam int KIND_W      = $clog2(NUM_KINDS);

	localparam logic [15:0] TARGET_RESET = 16'd1250;
	localparam logic [15:0] MAX16        = 16'hFFFF;

	typedef enum logic [1:0] {
		CAUSE_NONE     = 2'd0,
		CAUSE_MAGNETIC = 2'd1,
		CAUSE_NO_MATCH = 2'd2
	} cause_t;

	localparam logic [2:0] DENOM_REJECT = 3'd0;

	localparam logic [7:0] PROF_REF [NUM_KINDS][NUM_SENSORS] = '{
		'{8'd128, 8'd107, 8'd94,  8'd56,  8'd47, 8'd57,  8'd111, 8'd86},
		'{8'd116, 8'd116, 8'd88,  8'd57,  8'd36, 8'd66,  8'd104, 8'd90},
		'{8'd111, 8'd167, 8'd97,  8'd78,  8'd30, 8'd116, 8'd100, 8'd121},
		'{8'd123, 8'd190, 8'd119, 8'd134, 8'd41, 8'd140, 8'd109, 8'd145}
	};

	localparam logic [7:0] PROF_TOL [NUM_KINDS][NUM_SENSORS] = '{
		'{8'd3, 8'd3, 8'd2, 8'd5,  8'd3, 8'd3, 8'd2, 8'd3},
		'{8'd4, 8'd5, 8'd3, 8'd3,  8'd4, 8'd5, 8'd3, 8'd2},
		'{8'd3, 8'd8, 8'd3, 8'd20, 8'd3, 8'd6, 8'd2, 8'd4},
		'{8'd2, 8'd2, 8'd4, 8'd20, 8'd4, 8'd3, 8'd3, 8'd3}
	};

	localparam logic [15:0] KIND_VALUE [NUM_KINDS] = '{16'd10, 16'd50, 16'd100, 16'd500};

	typedef struct packed {
		logic [7:0] magnetic;
		logic [7:0] sensor_0;
		logic [7:0] sensor_1;
		logic [7:0] sensor_2;
		logic [7:0] sensor_3;
		logic [7:0] sensor_4;
		logic [7:0] sensor_5;
		logic [7:0] sensor_6;
		logic [7:0] sensor_7;
	} in_word_t;

	typedef struct packed {
		logic [2:0]  denomination;
		logic [1:0]  reject_cause;
		logic [15:0] coin_count;
		logic [15:0] paid_total;
		logic [15:0] amount_left;
		logic        sale_done;
	} out_word_t;

	typedef struct packed {
		logic              hit;
		logic [KIND_W-1:0] kind;
		cause_t            cause;
	} cls_t;

endpackage

// ===== rtl/coin_validator_accumulator.sv =====
// Coin validator accumulator, top level. One coin word per cycle enters an input
// register while in_stall is low; there it is classified, and when the output
// stage can advance the total and per-coin counts are updated and the result
// word is registered. Throughput is one coin per cycle, limited only by the
// output handshake. Total and counts saturate at 65535 and clear when the sale
// completes. target_amount is written through cfg_we/cfg_wdata while the block
// is idle; the user must keep to this, the block itself does not enforce it.
// depends on cva_pkg and cva_classify
module coin_validator_accumulator (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  cva_pkg::in_word_t  in_word,
	output logic               out_valid,
	input  logic               out_stall,
	output cva_pkg::out_word_t out_word,
	input  logic               cfg_we,
	input  logic [15:0]        cfg_wdata
);
	import cva_pkg::*;

	in_word_t    word_s1;
	logic        valid_s1;
	out_word_t   word_s2;
	logic        valid_s2;
	logic [15:0] target_q;
	logic [15:0] total_q;
	logic [15:0] count_q [NUM_KINDS];

	cls_t        cls;
	logic        adv_s2;
	logic        fire_s1;
	logic [16:0] total_sum;
	logic [15:0] total_next;
	logic [15:0] count_sel;
	logic [15:0] count_next;
	logic        done;

	cva_classify u_classify (
		.coin (word_s1),
		.cls  (cls)
	);

	assign adv_s2   = !valid_s2 || !out_stall;
	assign in_stall = valid_s1 && !adv_s2;
	assign fire_s1  = valid_s1 && adv_s2;

	always_comb begin
		count_sel  = count_q[cls.kind];
		count_next = (count_sel == MAX16) ? count_sel : count_sel + 16'd1;
		total_sum  = {1'b0, total_q} + {1'b0, KIND_VALUE[cls.kind]};
		if (cls.hit) begin
			total_next = total_sum[16] ? MAX16 : total_sum[15:0];
		end else begin
			total_next = total_q;
		end
		done = (total_next >= target_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!valid_s1 || adv_s2) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			word_s1 <= in_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			word_s2.denomination <= cls.hit ? {1'b0, cls.kind} + 3'd1 : DENOM_REJECT;
			word_s2.reject_cause <= cls.cause;
			word_s2.coin_count   <= cls.hit ? count_next : 16'd0;
			word_s2.paid_total   <= total_next;
			word_s2.amount_left  <= done ? 16'd0 : target_q - total_next;
			word_s2.sale_done    <= done;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= TARGET_RESET;
		end else if (cfg_we) begin
			target_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
			for (int k = 0; k < NUM_KINDS; k++) begin
				count_q[k] <= '0;
			end
		end else if (fire_s1) begin
			if (done) begin
				total_q <= '0;
				for (int k = 0; k < NUM_KINDS; k++) begin
					count_q[k] <= '0;
				end
			end else begin
				total_q <= total_next;
				if (cls.hit) begin
					count_q[cls.kind] <= count_next;
				end
			end
		end
	end

	assign out_valid = valid_s2;
	assign out_word  = word_s2;

endmodule

// ===== rtl/cva_classify.sv =====
// coin classification: magnetic check and priority match against the four profiles
// depends on cva_pkg
module cva_classify (
	input  cva_pkg::in_word_t coin,
	output cva_pkg::cls_t     cls
);
	import cva_pkg::*;

	logic [7:0]           rd [NUM_SENSORS];
	logic [NUM_KINDS-1:0] fits;

	assign rd[0] = coin.sensor_0;
	assign rd[1] = coin.sensor_1;
	assign rd[2] = coin.sensor_2;
	assign rd[3] = coin.sensor_3;
	assign rd[4] = coin.sensor_4;
	assign rd[5] = coin.sensor_5;
	assign rd[6] = coin.sensor_6;
	assign rd[7] = coin.sensor_7;

	always_comb begin
		logic [7:0] diff;
		for (int k = 0; k < NUM_KINDS; k++) begin
			fits[k] = 1'b1;
			for (int s = 0; s < NUM_SENSORS; s++) begin
				diff = (rd[s] > PROF_REF[k][s]) ? rd[s] - PROF_REF[k][s]
				                                : PROF_REF[k][s] - rd[s];
				if (diff > PROF_TOL[k][s]) begin
					fits[k] = 1'b0;
				end
			end
		end
	end

	// lowest profile index wins
	always_comb begin
		cls.hit  = 1'b0;
		cls.kind = '0;
		for (int k = NUM_KINDS - 1; k >= 0; k--) begin
			if (fits[k]) begin
				cls.hit  = 1'b1;
				cls.kind = KIND_W'(k);
			end
		end
		priority if (coin.magnetic != 8'd0) begin
			cls.hit   = 1'b0;
			cls.cause = CAUSE_MAGNETIC;
		end else if (cls.hit) begin
			cls.cause = CAUSE_NONE;
		end else begin
			cls.cause = CAUSE_NO_MATCH;
		end
	end

endmodule

// ===== rtl/cva_checker.sv =====
// port-level checks for coin_validator_accumulator, attached by bind
// depends on cva_pkg
module cva_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_stall,
	input cva_pkg::out_word_t out_word
);
	import cva_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_word))
		else $error("result word dropped or changed while stalled");

	a_done_left: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_word.sale_done |-> out_word.amount_left == 16'd0)
		else $error("completed sale reports an amount left");

	a_reject_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_word.reject_cause != CAUSE_NONE |->
			out_word.denomination == DENOM_REJECT && out_word.coin_count == 16'd0)
		else $error("rejected coin shows a denomination or count");

	a_accept_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_word.reject_cause == CAUSE_NONE |->
			out_word.denomination != DENOM_REJECT && out_word.coin_count != 16'd0
			&& out_word.paid_total != 16'd0)
		else $error("accepted coin without denomination, count or total");

endmodule

bind coin_validator_accumulator cva_checker u_cva_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_word  (out_word)
);

// ===== dv/tb_coin_validator_accumulator.sv =====
`timescale 1ns / 100ps
// testbench for coin_validator_accumulator: directed and random coin words checked
// against a behavioral model of the profile match and the payment total
// depends on cva_pkg and the coin_validator_accumulator rtl
module tb_coin_validator_accumulator;
	import cva_pkg::*;

	localparam int LOG_DEPTH     = 8192;
	localparam int IDLE_LIMIT    = 2000;
	localparam int SETTLE_CYCLES = 4;
	localparam int MAX_REPORTS   = 10;

	localparam logic [2:0] COIN_10  = 3'd1;
	localparam logic [2:0] COIN_50  = 3'd2;
	localparam logic [2:0] COIN_100 = 3'd3;
	localparam logic [2:0] COIN_500 = 3'd4;
	localparam logic [2:0] COIN_CODE [4] = '{COIN_10, COIN_50, COIN_100, COIN_500};

	localparam int KIND_10  = 0;
	localparam int KIND_50  = 1;
	localparam int KIND_100 = 2;
	localparam int KIND_500 = 3;

	localparam logic [7:0] REF_TAB [4][8] = '{
		'{8'd128, 8'd107, 8'd94,  8'd56,  8'd47, 8'd57,  8'd111, 8'd86},
		'{8'd116, 8'd116, 8'd88,  8'd57,  8'd36, 8'd66,  8'd104, 8'd90},
		'{8'd111, 8'd167, 8'd97,  8'd78,  8'd30, 8'd116, 8'd100, 8'd121},
		'{8'd123, 8'd190, 8'd119, 8'd134, 8'd41, 8'd140, 8'd109, 8'd145}
	};
	localparam logic [7:0] TOL_TAB [4][8] = '{
		'{8'd3, 8'd3, 8'd2, 8'd5,  8'd3, 8'd3, 8'd2, 8'd3},
		'{8'd4, 8'd5, 8'd3, 8'd3,  8'd4, 8'd5, 8'd3, 8'd2},
		'{8'd3, 8'd8, 8'd3, 8'd20, 8'd3, 8'd6, 8'd2, 8'd4},
		'{8'd2, 8'd2, 8'd4, 8'd20, 8'd4, 8'd3, 8'd3, 8'd3}
	};
	localparam logic [16:0] VALUE_TAB [4] = '{17'd10, 17'd50, 17'd100, 17'd500};

	typedef enum logic [1:0] {
		ACT_COIN,
		ACT_SET_TARGET,
		ACT_DRAIN
	} act_kind_t;

	typedef struct {
		act_kind_t   kind;
		in_word_t    word;
		logic [15:0] value;
		int          gap;
	} act_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic        in_stall;
	in_word_t    in_word   = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	out_word_t   out_word;
	logic        cfg_we    = 1'b0;
	logic [15:0] cfg_wdata = '0;

	act_t      coin_feed [$];
	out_word_t results_due [LOG_DEPTH];
	int        coins_in    = 0;
	int        results_out = 0;
	logic      feed_empty  = 1'b0;
	int        mismatches  = 0;
	int        gap_left    = 0;
	int        settle      = 0;
	int        stall_left  = 0;
	int        idle_cycles = 0;
	bit        calm_in     = 1'b0;
	bit        calm_out    = 1'b0;

	// model state
	logic [15:0] target_mdl = TARGET_RESET;
	logic [15:0] total_mdl  = '0;
	logic [15:0] count_mdl [4] = '{default: '0};

	coin_validator_accumulator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_word   (in_word),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_word  (out_word),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always #4 clk = ~clk;

	function automatic logic fits_profile(in_word_t w, int k);
		logic [7:0] rd [8];
		int d;
		rd = '{w.sensor_0, w.sensor_1, w.sensor_2, w.sensor_3,
			w.sensor_4, w.sensor_5, w.sensor_6, w.sensor_7};
		for (int s = 0; s < 8; s++) begin
			d = int'(rd[s]) - int'(REF_TAB[k][s]);
			if (d < 0)
				d = -d;
			if (d > int'(TOL_TAB[k][s]))
				return 1'b0;
		end
		return 1'b1;
	endfunction

	function automatic out_word_t predict_coin(in_word_t w);
		out_word_t r;
		int hit;
		logic [16:0] sum;
		r = '0;
		r.denomination = DENOM_REJECT;
		hit = -1;
		if (w.magnetic != 8'd0) begin
			r.reject_cause = CAUSE_MAGNETIC;
		end else begin
			r.reject_cause = CAUSE_NO_MATCH;
			for (int k = 0; k < 4; k++)
				if (hit < 0 && fits_profile(w, k))
					hit = k;
			if (hit >= 0) begin
				r.reject_cause = CAUSE_NONE;
				r.denomination = COIN_CODE[hit];
				if (count_mdl[hit] != MAX16)
					count_mdl[hit] = count_mdl[hit] + 16'd1;
				r.coin_count = count_mdl[hit];
				sum = {1'b0, total_mdl} + VALUE_TAB[hit];
				total_mdl = sum[16] ? MAX16 : sum[15:0];
			end
		end
		r.paid_total = total_mdl;
		r.sale_done = total_mdl >= target_mdl;
		r.amount_left = r.sale_done ? 16'd0 : target_mdl - total_mdl;
		if (r.sale_done) begin
			total_mdl = '0;
			for (int k = 0; k < 4; k++)
				count_mdl[k] = '0;
		end
		return r;
	endfunction

	function automatic logic [7:0] to_byte(int v);
		if (v < 0)
			return 8'd0;
		if (v > 255)
			return 8'd255;
		return 8'(v);
	endfunction

	function automatic logic [7:0] jitter(int centre, int tol, bit stray);
		int v;
		if (stray)
			v = $urandom_range(0, 1) ? centre + tol + 1 + int'($urandom_range(0, 2))
				: centre - tol - 1 - int'($urandom_range(0, 2));
		else
			v = centre + int'($urandom_range(0, 2 * tol)) - tol;
		return to_byte(v);
	endfunction

	function automatic in_word_t pack_word(logic [7:0] mag, logic [7:0] rd [8]);
		in_word_t w;
		w.magnetic = mag;
		w.sensor_0 = rd[0];
		w.sensor_1 = rd[1];
		w.sensor_2 = rd[2];
		w.sensor_3 = rd[3];
		w.sensor_4 = rd[4];
		w.sensor_5 = rd[5];
		w.sensor_6 = rd[6];
		w.sensor_7 = rd[7];
		return w;
	endfunction

	// every reading moved by shift times the tolerance
	function automatic in_word_t profile_coin(int k, int shift);
		logic [7:0] rd [8];
		for (int i = 0; i < 8; i++)
			rd[i] = to_byte(int'(REF_TAB[k][i]) + shift * int'(TOL_TAB[k][i]));
		return pack_word(8'd0, rd);
	endfunction

	function automatic in_word_t shaped_coin(int k, int strays, logic [7:0] mag);
		logic [7:0] rd [8];
		int pick;
		for (int i = 0; i < 8; i++)
			rd[i] = jitter(int'(REF_TAB[k][i]), int'(TOL_TAB[k][i]), 1'b0);
		for (int j = 0; j < strays; j++) begin
			pick = $urandom_range(0, 7);
			rd[pick] = jitter(int'(REF_TAB[k][pick]), int'(TOL_TAB[k][pick]), 1'b1);
		end
		return pack_word(mag, rd);
	endfunction

	function automatic in_word_t random_coin(bit big);
		int pick;
		int k;
		logic [95:0] raw;
		in_word_t w;
		pick = $urandom_range(0, 99);
		k = (big && $urandom_range(0, 19) != 0) ? KIND_500 : int'($urandom_range(0, 3));
		if (pick < 70) begin
			w = shaped_coin(k, 0, 8'd0);
		end else if (pick < 80) begin
			w = shaped_coin(k, $urandom_range(1, 2), 8'd0);
		end else if (pick < 88) begin
			w = shaped_coin(k, 0, 8'($urandom_range(1, 255)));
		end else begin
			raw = {$urandom(), $urandom(), $urandom()};
			w = raw[71:0];
			if ($urandom_range(0, 1))
				w.magnetic = 8'd0;
		end
		return w;
	endfunction

	task automatic add_coin(in_word_t w);
		act_t a;
		a.kind = ACT_COIN;
		a.word = w;
		a.value = '0;
		a.gap = calm_in ? 0 : int'($urandom_range(0, 6));
		coin_feed.push_back(a);
	endtask

	task automatic add_target(logic [15:0] v);
		act_t a;
		a.kind = ACT_SET_TARGET;
		a.word = '0;
		a.value = v;
		a.gap = 0;
		coin_feed.push_back(a);
	endtask

	task automatic add_drain();
		act_t a;
		a.kind = ACT_DRAIN;
		a.word = '0;
		a.value = '0;
		a.gap = 0;
		coin_feed.push_back(a);
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		logic nxt_valid;
		in_word_t nxt_word;
		logic nxt_we;
		logic [15:0] nxt_wdata;
		int nxt_in;
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_word <= '0;
			cfg_we <= 1'b0;
			cfg_wdata <= '0;
			coins_in <= 0;
			feed_empty <= 1'b0;
			gap_left = 0;
			settle = 0;
		end else begin
			nxt_valid = in_valid;
			nxt_word = in_word;
			nxt_we = 1'b0;
			nxt_wdata = cfg_wdata;
			nxt_in = coins_in;
			if (in_valid && !in_stall) begin
				results_due[coins_in % LOG_DEPTH] <= predict_coin(in_word);
				nxt_in = coins_in + 1;
				nxt_valid = 1'b0;
			end
			if (!nxt_valid) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (coin_feed.size() != 0) begin
					case (coin_feed[0].kind)
						ACT_COIN: begin
							nxt_valid = 1'b1;
							nxt_word = coin_feed[0].word;
							gap_left = coin_feed[0].gap;
							void'(coin_feed.pop_front());
						end
						ACT_SET_TARGET: begin
							if (nxt_in == results_out && !cfg_we)
								settle++;
							else
								settle = 0;
							if (settle >= SETTLE_CYCLES) begin
								nxt_we = 1'b1;
								nxt_wdata = coin_feed[0].value;
								target_mdl = coin_feed[0].value;
								settle = 0;
								void'(coin_feed.pop_front());
							end
						end
						default: begin
							if (nxt_in == results_out)
								void'(coin_feed.pop_front());
						end
					endcase
				end
			end
			in_valid <= nxt_valid;
			in_word <= nxt_word;
			cfg_we <= nxt_we;
			cfg_wdata <= nxt_wdata;
			coins_in <= nxt_in;
			feed_empty <= coin_feed.size() == 0;
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		out_word_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
			results_out <= 0;
			stall_left = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (results_out == coins_in) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("unexpected result word %p", out_word);
				end else begin
					want = results_due[results_out % LOG_DEPTH];
					if (out_word.denomination !== want.denomination
						|| out_word.reject_cause !== want.reject_cause
						|| out_word.coin_count !== want.coin_count
						|| out_word.paid_total !== want.paid_total
						|| out_word.amount_left !== want.amount_left
						|| out_word.sale_done !== want.sale_done) begin
						mismatches++;
						if (mismatches <= MAX_REPORTS)
							$display("coin %0d: expected %p, got %p", results_out, want,
								out_word);
					end
					results_out <= results_out + 1;
				end
				if ($urandom_range(0, 49) == 0)
					calm_out = !calm_out;
				stall_left = calm_out ? 0 : int'($urandom_range(0, 6));
			end else if (stall_left > 0) begin
				stall_left--;
			end
			out_stall <= stall_left > 0;
		end
	end

	// watchdog on lack of progress
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
			idle_cycles <= 0;
		end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
			$display("watchdog: no word moved for %0d cycles", IDLE_LIMIT);
			$display("tb_coin_validator_accumulator failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		in_word_t w;
		logic [15:0] t;
		int n;
		bit big;

		// directed, reset target of 1250
		add_coin(profile_coin(KIND_10, 0));
		add_coin(profile_coin(KIND_50, 1));
		add_coin(profile_coin(KIND_100, -1));
		add_coin(profile_coin(KIND_500, 0));
		w = profile_coin(KIND_500, 0);
		w.magnetic = 8'h01;
		add_coin(w);
		w.magnetic = 8'hFF;
		add_coin(w);
		w.magnetic = 8'h80;
		add_coin(w);
		add_coin('0);
		w = '1;
		w.magnetic = 8'd0;
		add_coin(w);
		add_coin(profile_coin(KIND_10, 2));
		add_coin(profile_coin(KIND_500, -2));
		// overshoot
		add_coin(profile_coin(KIND_500, -1));
		add_coin(profile_coin(KIND_100, 1));
		// exact hit
		add_coin(profile_coin(KIND_500, 1));
		add_coin(profile_coin(KIND_500, 0));
		add_coin(profile_coin(KIND_100, 0));
		add_coin(profile_coin(KIND_100, 0));
		add_coin(profile_coin(KIND_50, -1));
		add_drain();
		// zero target completes on any coin
		add_target(16'd0);
		add_coin('0);
		w = profile_coin(KIND_10, 0);
		w.magnetic = 8'h55;
		add_coin(w);
		add_coin(profile_coin(KIND_10, 1));
		add_target(16'd1);
		add_coin(profile_coin(KIND_10, -1));

		// random phases
		for (int ph = 0; ph < 12; ph++) begin
			big = 1'b0;
			case (ph)
				0, 7: begin
					t = 16'hFFFF;
					big = 1'b1;
				end
				3: t = 16'd0;
				9: t = 16'd1;
				11: t = TARGET_RESET;
				default: t = 16'($urandom_range(20, 3000));
			endcase
			add_target(t);
			n = big ? 260 : 70;
			for (int i = 0; i < n; i++) begin
				if (i % 30 == 0)
					calm_in = $urandom_range(0, 3) == 0;
				if (i == n / 2)
					add_drain();
				add_coin(random_coin(big));
			end
		end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		do
			@(posedge clk);
		while (!feed_empty || in_valid || coins_in != results_out);
		repeat (8) @(posedge clk);
		if (mismatches == 0 && coins_in == results_out) begin
			$display("tb_coin_validator_accumulator passed");
		end else begin
			$display("tb_coin_validator_accumulator failed");
		end
		$finish;
	end

endmodule
